// ===== hw/rtl/fema_pkg.sv =====
package fema_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_COUNT_WIDTH = 20;

    localparam int SUM_W = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int CORDIC_STEPS = 24;
    localparam int NORM_BIT = 29;

    localparam logic [2:0] MODE_MSE   = 3'd0;
    localparam logic [2:0] MODE_RMSE  = 3'd1;
    localparam logic [2:0] MODE_MAE   = 3'd2;
    localparam logic [2:0] MODE_SMAPE = 3'd3;
    localparam logic [2:0] MODE_MAPE  = 3'd4;
    localparam logic [2:0] MODE_MAAPE = 3'd5;
    localparam logic [2:0] MODE_MASE  = 3'd6;

    localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PCT_LIMIT = 64'd184467440737095516;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [2:0]  mode;
        logic        last;
        logic        both_zero;
        logic [63:0] d;
        logic [63:0] av;
        logic [63:0] den;
        logic [63:0] nd;
    } fema_item_t;

    function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:  v = 33'sd843314857;
            5'd1:  v = 33'sd497837829;
            5'd2:  v = 33'sd263043837;
            5'd3:  v = 33'sd133525159;
            5'd4:  v = 33'sd67021687;
            5'd5:  v = 33'sd33543516;
            5'd6:  v = 33'sd16775851;
            5'd7:  v = 33'sd8388437;
            5'd8:  v = 33'sd4194283;
            5'd9:  v = 33'sd2097149;
            5'd10: v = 33'sd1048576;
            5'd11: v = 33'sd524288;
            5'd12: v = 33'sd262144;
            5'd13: v = 33'sd131072;
            5'd14: v = 33'sd65536;
            5'd15: v = 33'sd32768;
            5'd16: v = 33'sd16384;
            5'd17: v = 33'sd8192;
            5'd18: v = 33'sd4096;
            5'd19: v = 33'sd2048;
            5'd20: v = 33'sd1024;
            5'd21: v = 33'sd512;
            5'd22: v = 33'sd256;
            5'd23: v = 33'sd128;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/forecast_error_metric_accumulator_top.sv =====
// Accumulates one forecast error metric (mse, rmse, mae, smape, mape, maape or mase, chosen by
// the metric mode written on cfg_wr_en) over a series of Q16.16 items and returns one result
// when the item marked last has been processed. A front stage classifies each item into a
// two-entry queue; a back-end sequencer forms each term with shared multi-cycle units. Per item
// the back end takes a direct path for mae, mase and zero-valued pairs, sums four
// 32x32 partial products for mse and rmse, runs a bit-serial divider for smape and mape, and
// uses one-bit normalize shifts plus 24 CORDIC steps for maape. The last item adds one pass
// of the divider (not for mase with a zero scale sum), the square root in rmse and output.
// The result waits in an output register, so the next series proceeds while it is pending.
module forecast_error_metric_accumulator_top #(
    parameter int DATA_WIDTH  = fema_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS   = fema_pkg::DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = fema_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_actual_value,
    input  logic signed [DATA_WIDTH-1:0] s_forecast_value,
    input  logic signed [DATA_WIDTH-1:0] s_naive_value,
    input  logic                         s_last_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [DATA_WIDTH-1:0]        m_metric_value,
    output logic                         m_saturated_flag
);
    import fema_pkg::*;

    fema_item_t push_item, head_item;
    logic q_push, q_full, q_pop, q_not_empty;

    fema_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_actual_value(s_actual_value), .s_forecast_value(s_forecast_value),
        .s_naive_value(s_naive_value), .s_last_item(s_last_item),
        .q_full(q_full), .q_push(q_push), .q_item(push_item)
    );

    fema_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_item(push_item), .full(q_full),
        .pop(q_pop), .not_empty(q_not_empty), .head_item(head_item)
    );

    fema_back #(
        .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_not_empty(q_not_empty), .q_head(head_item), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_metric_value(m_metric_value), .m_saturated_flag(m_saturated_flag)
    );

endmodule

// ===== hw/rtl/fema_front.sv =====
module fema_front #(
    parameter int DATA_WIDTH = fema_pkg::DEF_DATA_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_actual_value,
    input  logic signed [DATA_WIDTH-1:0] s_forecast_value,
    input  logic signed [DATA_WIDTH-1:0] s_naive_value,
    input  logic                         s_last_item,
    input  logic                         q_full,
    output logic                         q_push,
    output fema_pkg::fema_item_t         q_item
);
    import fema_pkg::*;

    logic [2:0] mode_reg;
    logic signed [63:0] a, f, n;
    logic [63:0] av, fv, smape_den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MSE;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        a = 64'(s_actual_value);
        f = 64'(s_forecast_value);
        n = 64'(s_naive_value);
        av = a[63] ? 64'(-a) : 64'(a);
        fv = f[63] ? 64'(-f) : 64'(f);
        smape_den = (av >> 1) + (fv >> 1) + {63'b0, av[0] & fv[0]};
        q_item.mode = mode_reg;
        q_item.last = s_last_item;
        q_item.both_zero = (a == 64'sd0) && (f == 64'sd0);
        q_item.d = (a >= f) ? 64'(a - f) : 64'(f - a);
        q_item.av = av;
        q_item.den = (mode_reg == MODE_SMAPE) ? smape_den : av;
        q_item.nd = (a >= n) ? 64'(a - n) : 64'(n - a);
    end

    assign s_ready = !q_full;
    assign q_push = s_valid && !q_full;

endmodule

// ===== hw/rtl/fema_queue.sv =====
module fema_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  fema_pkg::fema_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output fema_pkg::fema_item_t head_item
);
    import fema_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fema_item_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic do_push, do_pop;

    assign full = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;
    assign head_item = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                mem_reg[wptr_reg] <= push_item;
                wptr_reg <= (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/fema_back.sv =====
module fema_back #(
    parameter int DATA_WIDTH  = fema_pkg::DEF_DATA_WIDTH,
    parameter int FRAC_BITS   = fema_pkg::DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = fema_pkg::DEF_COUNT_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_not_empty,
    input  fema_pkg::fema_item_t  q_head,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_metric_value,
    output logic                  m_saturated_flag
);
    import fema_pkg::*;

    localparam int EXT_W = SUM_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(EXT_W + 1);
    localparam logic [63:0] OMAX = (DATA_WIDTH >= 64) ? ALL64 :
                                   64'((65'(1) << DATA_WIDTH) - 65'(1));

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MUL, S_SQ, S_DIV, S_NORM, S_CORDIC,
        S_ACC, S_FIN, S_POST, S_SQRT, S_SAT
    } state_t;

    state_t st_reg;
    fema_item_t cur_reg;
    logic [127:0] acc_reg;
    logic [1:0] mcnt_reg;
    logic [63:0] add_reg, term_sum_reg, scale_sum_reg, res_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic tfl_reg, ovf_reg, fin_reg, ffl_reg;
    logic [EXT_W-1:0] dnum_reg;
    logic [63:0] dden_reg, dr_reg, dq_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic signed [63:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic [4:0] icnt_reg;
    logic [127:0] rad_reg;
    logic [67:0] rem_reg;
    logic [63:0] root_reg;
    logic [6:0] scnt_reg;
    logic ov_reg;
    logic [DATA_WIDTH-1:0] mv_reg;
    logic mf_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [127:0] mul_sh;
    logic [63:0] rsh, rnew, qnew;
    logic dge;
    logic signed [63:0] xs, ys, xn, yn;
    logic signed [32:0] zn;
    logic [63:0] mx;
    logic [67:0] remsh, trial;
    logic sge;
    logic [64:0] tadd, sadd;
    logic [63:0] scale_in;
    logic acc_fl;

    always_comb begin
        mul_a = mcnt_reg[0] ? cur_reg.d[63:32] : cur_reg.d[31:0];
        mul_b = mcnt_reg[1] ? cur_reg.d[63:32] : cur_reg.d[31:0];
        mul_p = 64'(mul_a) * 64'(mul_b);
        mul_sh = 128'(mul_p) << (7'(mcnt_reg[0] + mcnt_reg[1]) * 7'd32);

        rsh = {dr_reg[62:0], dnum_reg[EXT_W-1]};
        dge = dr_reg[63] || (rsh >= dden_reg);
        rnew = dge ? rsh - dden_reg : rsh;
        qnew = {dq_reg[62:0], dge};

        xs = x_reg >>> icnt_reg;
        ys = y_reg >>> icnt_reg;
        if (!y_reg[63]) begin
            xn = x_reg + ys;
            yn = y_reg - xs;
            zn = z_reg + atan_q30(icnt_reg);
        end else begin
            xn = x_reg - ys;
            yn = y_reg + xs;
            zn = z_reg - atan_q30(icnt_reg);
        end
        mx = (x_reg > y_reg) ? x_reg : y_reg;

        remsh = {rem_reg[65:0], rad_reg[127:126]};
        trial = {2'b00, root_reg, 2'b01};
        sge = remsh >= trial;

        scale_in = (cur_reg.mode == MODE_MASE) ? cur_reg.nd : 64'd0;
        tadd = 65'(term_sum_reg) + 65'(add_reg);
        sadd = 65'(scale_sum_reg) + 65'(scale_in);
        acc_fl = tadd[64] || sadd[64] || (&count_reg);
    end

    assign q_pop = (st_reg == S_IDLE) && q_not_empty;
    assign m_valid = ov_reg;
    assign m_metric_value = mv_reg;
    assign m_saturated_flag = mf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            term_sum_reg <= '0;
            scale_sum_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            fin_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && m_ready && (st_reg != S_SAT)) begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (q_not_empty) begin
                        cur_reg <= q_head;
                        tfl_reg <= 1'b0;
                        st_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (cur_reg.mode)
                        MODE_MSE, MODE_RMSE: begin
                            acc_reg <= '0;
                            mcnt_reg <= '0;
                            st_reg <= S_MUL;
                        end
                        MODE_MAE, MODE_MASE: begin
                            add_reg <= cur_reg.d;
                            st_reg <= S_ACC;
                        end
                        MODE_SMAPE, MODE_MAPE: begin
                            if (cur_reg.both_zero) begin
                                add_reg <= '0;
                                st_reg <= S_ACC;
                            end else if (cur_reg.den == '0) begin
                                add_reg <= ALL64;
                                tfl_reg <= 1'b1;
                                st_reg <= S_ACC;
                            end else begin
                                dnum_reg <= {cur_reg.d, {FRAC_BITS{1'b0}}};
                                dden_reg <= cur_reg.den;
                                dr_reg <= '0;
                                dq_reg <= '0;
                                dcnt_reg <= DCNT_W'(EXT_W);
                                st_reg <= S_DIV;
                            end
                        end
                        MODE_MAAPE: begin
                            if (cur_reg.both_zero) begin
                                add_reg <= '0;
                                st_reg <= S_ACC;
                            end else if (cur_reg.av == '0) begin
                                add_reg <= PI_HALF_Q30 >> (30 - FRAC_BITS);
                                tfl_reg <= 1'b1;
                                st_reg <= S_ACC;
                            end else begin
                                x_reg <= cur_reg.av;
                                y_reg <= cur_reg.d;
                                z_reg <= '0;
                                icnt_reg <= '0;
                                st_reg <= S_NORM;
                            end
                        end
                        default: begin
                            add_reg <= '0;
                            st_reg <= S_ACC;
                        end
                    endcase
                end
                S_MUL: begin
                    acc_reg <= acc_reg + mul_sh;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == 2'd3) begin
                        st_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (acc_reg[127:64+FRAC_BITS] != '0) begin
                        add_reg <= ALL64;
                        tfl_reg <= 1'b1;
                    end else begin
                        add_reg <= acc_reg[FRAC_BITS +: 64];
                    end
                    st_reg <= S_ACC;
                end
                S_DIV: begin
                    if (dq_reg[63]) begin
                        if (fin_reg) begin
                            res_reg <= ALL64;
                            ffl_reg <= 1'b1;
                            st_reg <= S_POST;
                        end else begin
                            add_reg <= ALL64;
                            tfl_reg <= 1'b1;
                            st_reg <= S_ACC;
                        end
                    end else begin
                        dr_reg <= rnew;
                        dq_reg <= qnew;
                        dnum_reg <= dnum_reg << 1;
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (dcnt_reg == DCNT_W'(1)) begin
                            if (fin_reg) begin
                                res_reg <= qnew;
                                st_reg <= S_POST;
                            end else begin
                                add_reg <= qnew;
                                st_reg <= S_ACC;
                            end
                        end
                    end
                end
                S_NORM: begin
                    if (mx[63:NORM_BIT+1] != '0) begin
                        x_reg <= x_reg >>> 1;
                        y_reg <= y_reg >>> 1;
                    end else if (!mx[NORM_BIT]) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        st_reg <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    x_reg <= xn;
                    y_reg <= yn;
                    z_reg <= zn;
                    icnt_reg <= icnt_reg + 1'b1;
                    if (icnt_reg == 5'(CORDIC_STEPS - 1)) begin
                        add_reg <= zn[32] ? 64'd0 : 64'(zn >>> (30 - FRAC_BITS));
                        st_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    term_sum_reg <= tadd[64] ? ALL64 : tadd[63:0];
                    scale_sum_reg <= sadd[64] ? ALL64 : sadd[63:0];
                    if (!(&count_reg)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    ovf_reg <= ovf_reg | tfl_reg | acc_fl;
                    if (cur_reg.last) begin
                        fin_reg <= 1'b1;
                        ffl_reg <= ovf_reg | tfl_reg | acc_fl;
                        st_reg <= S_FIN;
                    end else begin
                        st_reg <= S_IDLE;
                    end
                end
                S_FIN: begin
                    dr_reg <= '0;
                    dq_reg <= '0;
                    dcnt_reg <= DCNT_W'(EXT_W);
                    if (cur_reg.mode == MODE_MASE) begin
                        if (scale_sum_reg == '0) begin
                            res_reg <= 64'(1) << FRAC_BITS;
                            st_reg <= S_SAT;
                        end else begin
                            dnum_reg <= {term_sum_reg, {FRAC_BITS{1'b0}}};
                            dden_reg <= scale_sum_reg;
                            st_reg <= S_DIV;
                        end
                    end else if (cur_reg.mode inside {[MODE_MSE:MODE_MAAPE]}) begin
                        dnum_reg <= EXT_W'(term_sum_reg);
                        dden_reg <= 64'(count_reg);
                        st_reg <= S_DIV;
                    end else begin
                        res_reg <= '0;
                        st_reg <= S_SAT;
                    end
                end
                S_POST: begin
                    if (cur_reg.mode inside {[MODE_SMAPE:MODE_MAAPE]}) begin
                        if (res_reg > PCT_LIMIT) begin
                            res_reg <= ALL64;
                            ffl_reg <= 1'b1;
                        end else begin
                            res_reg <= (res_reg << 6) + (res_reg << 5) + (res_reg << 2);
                        end
                        st_reg <= S_SAT;
                    end else if (cur_reg.mode == MODE_RMSE) begin
                        rad_reg <= 128'(res_reg) << FRAC_BITS;
                        rem_reg <= '0;
                        root_reg <= '0;
                        scnt_reg <= 7'd64;
                        st_reg <= S_SQRT;
                    end else begin
                        st_reg <= S_SAT;
                    end
                end
                S_SQRT: begin
                    rem_reg <= sge ? remsh - trial : remsh;
                    root_reg <= {root_reg[62:0], sge};
                    rad_reg <= rad_reg << 2;
                    scnt_reg <= scnt_reg - 1'b1;
                    if (scnt_reg == 7'd1) begin
                        res_reg <= {root_reg[62:0], sge};
                        st_reg <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (!ov_reg || m_ready) begin
                        ov_reg <= 1'b1;
                        mv_reg <= (res_reg > OMAX) ? OMAX[DATA_WIDTH-1:0] :
                                  res_reg[DATA_WIDTH-1:0];
                        mf_reg <= ffl_reg | (res_reg > OMAX);
                        term_sum_reg <= '0;
                        scale_sum_reg <= '0;
                        count_reg <= '0;
                        ovf_reg <= 1'b0;
                        fin_reg <= 1'b0;
                        st_reg <= S_IDLE;
                    end
                end
                default: begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/tb_forecast_error_metric_accumulator_top.sv =====
`timescale 1ns / 100ps

module tb_forecast_error_metric_accumulator_top;
    import fema_pkg::*;

    localparam int FRAC = 16;
    localparam int CNT_W = 20;
    localparam logic [2:0] MODE_NONE = 3'd7;
    localparam logic [63:0] PCT_MAX = 64'hFFFF_FFFF_FFFF_FFFF / 100;
    localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 1;
    localparam logic [63:0] ATAN_TAB [24] = '{
        64'd843314857, 64'd497837829, 64'd263043837, 64'd133525159, 64'd67021687,
        64'd33543516, 64'd16775851, 64'd8388437, 64'd4194283, 64'd2097149,
        64'd1048576, 64'd524288, 64'd262144, 64'd131072, 64'd65536, 64'd32768,
        64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024, 64'd512, 64'd256, 64'd128
    };

    typedef struct {
        logic [31:0] act;
        logic [31:0] fc;
        logic [31:0] nv;
        logic        last;
        int          gap;
    } pair_t;

    typedef struct {
        logic [31:0] value;
        logic        flag;
    } metric_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_actual_value;
    logic [31:0] s_forecast_value;
    logic [31:0] s_naive_value;
    logic        s_last_item;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_metric_value;
    logic        m_saturated_flag;

    pair_t   pending_pairs[$];
    metric_t expected_metrics[$];
    logic [2:0]  tb_mode;
    logic [63:0] err_sum;
    logic [63:0] base_sum;
    logic [63:0] pair_count;
    logic        sat_seen;
    int          send_gap;
    int          stall_left;
    int          errors;
    int          n_items;

    forecast_error_metric_accumulator_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_actual_value   (s_actual_value),
        .s_forecast_value (s_forecast_value),
        .s_naive_value    (s_naive_value),
        .s_last_item      (s_last_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_metric_value   (m_metric_value),
        .m_saturated_flag (m_saturated_flag)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #8ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y,
                                            inout logic fl);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s[64]) begin
            fl = 1'b1;
            return ALL64;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] q_div(input logic [63:0] num, input logic [63:0] den,
                                          inout logic fl);
        logic [127:0] q;
        if (den == 0) begin
            fl = 1'b1;
            return ALL64;
        end
        q = {48'd0, num, 16'd0} / {64'd0, den};
        if (q[127:64] != 0) begin
            fl = 1'b1;
            return ALL64;
        end
        return q[63:0];
    endfunction

    function automatic logic [63:0] q_square(input logic [63:0] d, inout logic fl);
        logic [127:0] p;
        p = {64'd0, d} * {64'd0, d};
        p = p >> FRAC;
        if (p[127:64] != 0) begin
            fl = 1'b1;
            return ALL64;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] q_sqrt(input logic [63:0] v);
        logic [127:0] vv;
        logic [63:0] r;
        logic [63:0] c;
        vv = {48'd0, v, 16'd0};
        r = 0;
        for (int b = 47; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= vv) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] ratio_angle(input logic [63:0] xin, input logic [63:0] yin);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic [63:0] m;
        longint z;
        int p;
        m = (xin > yin) ? xin : yin;
        p = 63;
        while (p > 0 && !m[p]) p--;
        if (p > 29) begin
            x = xin >> (p - 29);
            y = yin >> (p - 29);
        end else begin
            x = xin << (29 - p);
            y = yin << (29 - p);
        end
        z = 0;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0) z = 0;
        return 64'(z) >> (30 - FRAC);
    endfunction

    function automatic logic [63:0] abs_gap(input logic signed [63:0] x,
                                            input logic signed [63:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    task automatic accumulate_pair(input logic [31:0] act, input logic [31:0] fc,
                                   input logic [31:0] nv, input logic last);
        logic signed [63:0] a;
        logic signed [63:0] f;
        logic signed [63:0] n;
        logic [63:0] d;
        logic [63:0] av;
        logic [63:0] fv;
        logic [63:0] r;
        logic [63:0] t;
        logic fl;
        logic both_zero;
        metric_t res;
        a = 64'($signed(act));
        f = 64'($signed(fc));
        n = 64'($signed(nv));
        d = abs_gap(a, f);
        av = (a < 0) ? -a : a;
        fv = (f < 0) ? -f : f;
        both_zero = (a == 0) && (f == 0);
        fl = 1'b0;
        case (tb_mode)
            MODE_MSE, MODE_RMSE: begin
                t = q_square(d, fl);
                err_sum = sat_add(err_sum, t, fl);
            end
            MODE_MAE: err_sum = sat_add(err_sum, d, fl);
            MODE_SMAPE: if (!both_zero) begin
                t = q_div(d, (av >> 1) + (fv >> 1) + (av & fv & 64'd1), fl);
                err_sum = sat_add(err_sum, t, fl);
            end
            MODE_MAPE: if (!both_zero) begin
                t = q_div(d, av, fl);
                err_sum = sat_add(err_sum, t, fl);
            end
            MODE_MAAPE: if (!both_zero) begin
                if (av == 0) begin
                    fl = 1'b1;
                    err_sum = sat_add(err_sum, PI_HALF_Q30 >> (30 - FRAC), fl);
                end else begin
                    err_sum = sat_add(err_sum, ratio_angle(av, d), fl);
                end
            end
            MODE_MASE: begin
                err_sum = sat_add(err_sum, d, fl);
                base_sum = sat_add(base_sum, abs_gap(a, n), fl);
            end
            default: ;
        endcase
        if (pair_count < CNT_MAX) pair_count++;
        else fl = 1'b1;
        if (fl) sat_seen = 1'b1;
        if (!last) return;
        fl = sat_seen;
        r = 0;
        if (tb_mode == MODE_MASE) begin
            if (base_sum == 0) r = 64'd1 << FRAC;
            else r = q_div(err_sum, base_sum, fl);
        end else if (tb_mode != MODE_NONE) begin
            r = (pair_count != 0) ? err_sum / pair_count : err_sum;
            if (tb_mode >= MODE_SMAPE) begin
                if (r > PCT_MAX) begin
                    r = ALL64;
                    fl = 1'b1;
                end else begin
                    r = r * 100;
                end
            end
            if (tb_mode == MODE_RMSE) r = q_sqrt(r);
        end
        if (r > OUT_MAX) begin
            r = OUT_MAX;
            fl = 1'b1;
        end
        res.value = r[31:0];
        res.flag = fl;
        expected_metrics.push_back(res);
        err_sum = 0;
        base_sum = 0;
        pair_count = 0;
        sat_seen = 1'b0;
    endtask

    always @(posedge aclk) begin
        pair_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                accumulate_pair(s_actual_value, s_forecast_value, s_naive_value, s_last_item);
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_pairs.size() != 0) begin
                    it = pending_pairs.pop_front();
                    s_valid <= 1'b1;
                    s_actual_value <= it.act;
                    s_forecast_value <= it.fc;
                    s_naive_value <= it.nv;
                    s_last_item <= it.last;
                    send_gap = it.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        metric_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_metrics.size() == 0) begin
                    $display("%0t: unexpected result value=%h flag=%b", $realtime,
                             m_metric_value, m_saturated_flag);
                    errors++;
                end else begin
                    want = expected_metrics.pop_front();
                    if (m_metric_value !== want.value) begin
                        $display("%0t: metric_value expected %h actual %h", $realtime,
                                 want.value, m_metric_value);
                        errors++;
                    end
                    if (m_saturated_flag !== want.flag) begin
                        $display("%0t: saturated_flag expected %b actual %b", $realtime,
                                 want.flag, m_saturated_flag);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                m_ready <= (stall_left == 0);
            end
        end
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'd1;
                default: return 32'hFFFF_FFFF;
            endcase
            2, 3: return 32'($signed($urandom_range(0, 524288)) - 262144);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_pair(input logic [31:0] act, input logic [31:0] fc,
                            input logic [31:0] nv, input logic last);
        pair_t it;
        it.act = act;
        it.fc = fc;
        it.nv = nv;
        it.last = last;
        it.gap = pick_gap();
        pending_pairs.push_back(it);
        n_items++;
    endtask

    task automatic add_random_pair(input logic last);
        logic [31:0] a;
        logic [31:0] f;
        a = rand_val();
        case ($urandom_range(0, 9))
            0: f = a;
            1: f = -a;
            2: f = a + 32'($signed($urandom_range(0, 2000)) - 1000);
            default: f = rand_val();
        endcase
        add_pair(a, f, ($urandom_range(0, 7) == 0) ? a : rand_val(), last);
    endtask

    task automatic drain_and_set_mode(input logic [2:0] mode);
        wait (pending_pairs.size() == 0 && !s_valid);
        wait (expected_metrics.size() == 0);
        repeat (400) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        tb_mode = mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int len;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_actual_value = '0;
        s_forecast_value = '0;
        s_naive_value = '0;
        s_last_item = 1'b0;
        m_ready = 1'b0;
        tb_mode = MODE_MSE;
        err_sum = 0;
        base_sum = 0;
        pair_count = 0;
        sat_seen = 1'b0;
        send_gap = 0;
        stall_left = 0;
        errors = 0;
        n_items = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int m = 0; m < 8; m++) begin
            drain_and_set_mode(3'(m));
            add_pair(32'd0, 32'd0, 32'd0, 1'b0);
            add_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
            add_pair(32'd0, 32'd5, 32'd7, (m != int'(MODE_MAE)));
        end
        drain_and_set_mode(MODE_MAPE);
        add_pair(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 1'b1);
        drain_and_set_mode(MODE_MASE);
        add_pair(32'h0003_0000, 32'h0001_0000, 32'h0003_0000, 1'b0);
        add_pair(32'hFFFF_0000, 32'd0, 32'hFFFF_0000, 1'b1);

        while (n_items < 2000) begin
            drain_and_set_mode(3'($urandom_range(0, 7)));
            repeat ($urandom_range(1, 6)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) add_random_pair(i == len - 1);
            end
            if ($urandom_range(0, 3) == 0) add_random_pair(1'b0);
        end
        add_random_pair(1'b1);

        wait (pending_pairs.size() == 0 && !s_valid);
        wait (expected_metrics.size() == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== forecast_error_metric_accumulator_top.f =====
hw/rtl/fema_pkg.sv
hw/rtl/fema_front.sv
hw/rtl/fema_queue.sv
hw/rtl/fema_back.sv
hw/rtl/forecast_error_metric_accumulator_top.sv
verif/tb_forecast_error_metric_accumulator_top.sv
